/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising edge while reset is released.
`define IDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define IDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IDC_ASSERT(lbl, clk, rstn, prop, msg)
`define IDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/idc_pkg.sv */
// ---------------------------------------------------------------------------
// idc_pkg
// Constants and types shared by the decimal text converter and its cells.
// ---------------------------------------------------------------------------
`default_nettype none

package idc_pkg;

  localparam int DEF_VALUE_WIDTH = 32;

  // Magnitude bits consumed by every cell in one conversion cycle.
  localparam int STEPS = 4;

  localparam int DIGIT_W     = 4;
  localparam int OUT_CODE_W  = 8;
  localparam int OUT_COUNT_W = 4;

  // Shift-and-add-3 correction: a digit of five or more gets three added
  // before it is doubled.
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

  localparam logic [OUT_CODE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [OUT_CODE_W-1:0] ASCII_MINUS = 8'h2D;

  // log10(2) as a ratio, used to size the digit chain.
  localparam int LOG2_NUM = 30103;
  localparam int LOG2_DEN = 100000;

  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // run one conversion cycle
    logic shift;  // take the lower neighbor's digit
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/idc_cell.sv */
// ---------------------------------------------------------------------------
// idc_cell
// One decimal digit of the conversion chain.
// ---------------------------------------------------------------------------
`default_nettype none

module idc_cell (
  input  logic                          clk,
  input  idc_pkg::cell_ctrl_t           ctrl,
  input  logic [idc_pkg::STEPS-1:0]     carry_in,
  input  logic [idc_pkg::DIGIT_W-1:0]   digit_in,
  output logic [idc_pkg::STEPS-1:0]     carry_out,
  output logic [idc_pkg::DIGIT_W-1:0]   digit
);
  import idc_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] conv_d;

  // Several shift-and-add-3 steps per cycle; bit s comes from the lower
  // neighbor's step s and the bit pushed out goes to the upper neighbor.
  always_comb begin
    logic [DIGIT_W-1:0] d;
    logic [DIGIT_W-1:0] adj;
    d = digit_r;
    for (int s = 0; s < STEPS; s++) begin
      adj          = (d >= ADJ_LIMIT) ? (d + ADJ_ADD) : d;
      carry_out[s] = adj[DIGIT_W-1];
      d            = {adj[DIGIT_W-2:0], carry_in[s]};
    end
    conv_d = d;
  end

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = conv_d;
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

`default_nettype wire

/* sv/int_to_decimal_ascii_top.sv */
// ---------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Signed integer to decimal ASCII text, one character per result.
// ---------------------------------------------------------------------------
// Usage: drive in_value and raise start while busy is low; that edge is the
// input transfer. The block then emits the text of the value: a '-' for a
// negative value, then the digits from most to least significant with no
// leading zeros ('0' for zero). Each character is on out_char_code for one
// cycle with out_strobe high, together with the run length out_char_count,
// and out_last_char marks the final character. The receiver cannot stall,
// so every strobed character must be taken in the cycle it is shown.
// Sequence: after the transfer, the digit chain consumes four magnitude bits
// per cycle in ST_CONV until the padded magnitude is used up, ST_SIGN sizes
// the run and emits the sign, then in ST_EMIT the chain shifts one digit per
// cycle until every digit cell has reached the top. Leading zero digits
// pass silently. A new value is taken only once the control is back in
// idle.
// Reset returns the control to idle and drops the strobe; an item in
// progress is discarded.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module int_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = idc_pkg::DEF_VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [VALUE_WIDTH-1:0]     in_value,
  output logic                              out_strobe,
  output logic [idc_pkg::OUT_CODE_W-1:0]    out_char_code,
  output logic [idc_pkg::OUT_COUNT_W-1:0]   out_char_count,
  output logic                              out_last_char
);
  import idc_pkg::*;

  // Magnitude padded to whole conversion cycles, digits of 2^(W-1).
  localparam int PadW       = ((VALUE_WIDTH + STEPS - 1) / STEPS) * STEPS;
  localparam int ConvCycles = PadW / STEPS;
  localparam int NumDig     = ((VALUE_WIDTH - 1) * LOG2_NUM) / LOG2_DEN + 1;
  localparam int CntW       = $clog2(ConvCycles);
  localparam int PosW       = $clog2(NumDig);
  localparam int TotW       = $clog2(NumDig + 2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PadW-1:0]          mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [CntW-1:0]          conv_cnt_r, conv_cnt_nxt;
  logic [PosW-1:0]          pos_r, pos_nxt;
  logic [TotW-1:0]          ndig_r, ndig_nxt;
  logic [OUT_COUNT_W-1:0]   cnt_r, cnt_nxt;

  logic                     out_strobe_r, out_strobe_nxt;
  logic [OUT_CODE_W-1:0]    out_code_r, out_code_nxt;
  logic [OUT_COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     accept;
  logic [VALUE_WIDTH-1:0]   mag_w;
  logic [TotW-1:0]          ndig_w;
  logic [TotW-1:0]          total_w;
  cell_ctrl_t               ctrl;

  logic [STEPS-1:0]         carry_w  [NumDig+1];
  logic [DIGIT_W-1:0]       dig_w    [NumDig];
  logic [DIGIT_W-1:0]       dig_in_w [NumDig];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Two's complement magnitude; the most negative value yields 2^(W-1),
  // which still fits in W unsigned bits.
  assign mag_w = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  assign ctrl.clear = accept;
  assign ctrl.conv  = (state_r == ST_CONV);
  assign ctrl.shift = (state_r == ST_EMIT);

  // The lowest cell takes the magnitude most significant bit first; the
  // digit shift-out moves every digit one cell toward the top.
  for (genvar s = 0; s < STEPS; s++) begin : g_feed
    assign carry_w[0][s] = mag_r[PadW-1-s];
  end

  always_comb begin
    dig_in_w[0] = '0;
    for (int i = 1; i < NumDig; i++) begin
      dig_in_w[i] = dig_w[i-1];
    end
  end

  for (genvar g = 0; g < NumDig; g++) begin : g_cell
    idc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (carry_w[g]),
      .digit_in  (dig_in_w[g]),
      .carry_out (carry_w[g+1]),
      .digit     (dig_w[g])
    );
  end

  // Number of significant digits: position of the highest nonzero digit,
  // at least one so that zero prints as '0'.
  always_comb begin
    ndig_w = TotW'(1);
    for (int i = 0; i < NumDig; i++) begin
      if (dig_w[i] != '0) begin
        ndig_w = TotW'(i + 1);
      end
    end
  end

  assign total_w = ndig_w + TotW'(neg_r);

  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    conv_cnt_nxt   = conv_cnt_r;
    pos_nxt        = pos_r;
    ndig_nxt       = ndig_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_code_nxt   = ASCII_ZERO + OUT_CODE_W'(dig_w[NumDig-1]);
    out_count_nxt  = cnt_r;
    out_last_nxt   = (pos_r == '0);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mag_nxt      = PadW'(mag_w);
          neg_nxt      = in_value[VALUE_WIDTH-1];
          conv_cnt_nxt = CntW'(ConvCycles - 1);
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt      = mag_r << STEPS;
        conv_cnt_nxt = conv_cnt_r - 1'b1;
        if (conv_cnt_r == '0) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        ndig_nxt       = ndig_w;
        cnt_nxt        = OUT_COUNT_W'(total_w);
        pos_nxt        = PosW'(NumDig - 1);
        out_strobe_nxt = neg_r;
        out_code_nxt   = ASCII_MINUS;
        out_count_nxt  = OUT_COUNT_W'(total_w);
        out_last_nxt   = 1'b0;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        // The top cell holds the digit that started at cell pos_r; it is
        // shown only once the leading zeros have gone by.
        out_strobe_nxt = (TotW'(pos_r) < ndig_r);
        pos_nxt        = pos_r - 1'b1;
        if (pos_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    conv_cnt_r  <= conv_cnt_nxt;
    pos_r       <= pos_nxt;
    ndig_r      <= ndig_nxt;
    cnt_r       <= cnt_nxt;
    out_code_r  <= out_code_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_char_code  = out_code_r;
  assign out_char_count = out_count_r;
  assign out_last_char  = out_last_r;

  // The chain is sized for the largest magnitude, so nothing may ever be
  // pushed out of the top digit while converting.
  `IDC_ASSERT(a_no_overflow, clk, rst_n, (state_r == ST_CONV) |-> (carry_w[NumDig] == '0), "digit chain overflow")
  // A transfer always starts a conversion.
  `IDC_ASSERT_NEXT(a_accept_conv, clk, rst_n, accept, state_r == ST_CONV, "transfer did not start conversion")
  // Characters only come out of the sign and shift-out phases.
  `IDC_ASSERT(a_strobe_src, clk, rst_n, out_strobe |-> ($past(state_r) == ST_SIGN || $past(state_r) == ST_EMIT), "strobe outside emission")
  // The final character is shown as the control returns to idle.
  `IDC_ASSERT(a_last_idle, clk, rst_n, (out_strobe && out_last_char) |-> (state_r == ST_IDLE), "last character not at end of run")

endmodule

`default_nettype wire
